>>> hdl/sample_without_replacement_assert.svh
// ---------------------------------------------------------------------------
// sample without replacement assertion macros
// shared property shorthands for the sampler rtl, compiled out by NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef SAMPLE_WITHOUT_REPLACEMENT_ASSERT_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define SWR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define SWR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SWR_ASSERT(lbl, clk, rstn, prop, msg)

`define SWR_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> hdl/swr_pkg.sv
// ---------------------------------------------------------------------------
// swr_pkg
// shared types and codes of the sampler: commands, status codes, register map
// ---------------------------------------------------------------------------
package swr_pkg;

  // payload widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 64;
  localparam int POS_W   = 10;
  localparam int ST_W    = 2;
  localparam int PICK_W  = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_PICK  = 2'd0;
  localparam logic [ST_W-1:0] ST_ERROR = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE  = 2'd2;

  // register port geometry, one register per 4-byte word
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_REPLACE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PICK    = 1'd1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/sample_without_replacement.sv
// ---------------------------------------------------------------------------
// sample_without_replacement
// Draws elements from a loaded set of up to SET_DEPTH 64-bit words using
// externally supplied random words. A load or a clear completes in the idle
// state and gives no result. A draw that makes a pick passes through the
// bit-serial remainder unit that computes word mod bound. Without
// replacement this is followed by one pool read, one pool write with
// element read and the result stage; with replacement the pool steps give
// way to a single element read. A rejected word returns to idle with no
// result, and an error or done result goes from idle straight to the
// result stage. A result that finds the previous one still waiting in the
// output register waits until that one is taken. Without replacement the
// pick moves the last live pool entry into the chosen slot. The block takes
// one request at a time; the output register lets a finished result wait
// while the next request is accepted. The element and index stores are not
// cleared at reset and need no clearing pass.
// ---------------------------------------------------------------------------
`include "sample_without_replacement_assert.svh"

module sample_without_replacement import swr_pkg::*; #(
  parameter int SET_DEPTH   = 1024,
  parameter int RANDOM_BITS = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [VALUE_W-1:0]     value_i,
  input  logic [RANDOM_BITS-1:0] random_word_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_W-1:0]     picked_value_o,
  output logic [POS_W-1:0]       source_position_o,
  output logic [ST_W-1:0]        status_o,
  output logic                   last_pick_o,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int CMP_W = (CNT_W > PICK_W) ? CNT_W : PICK_W;
  localparam int SUM_W = ((RANDOM_BITS > CNT_W) ? RANDOM_BITS : CNT_W) + 1;

  localparam logic [RANDOM_BITS-1:0] WORD_TOP = '1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WRP  = 3'd2;
  localparam logic [2:0] S_ELM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       loaded_q, loaded_d;
  logic [CNT_W-1:0]       pool_rem_q, pool_rem_d;
  logic [PICK_W-1:0]      picks_q, picks_d;
  logic                   replace_q;
  logic [PICK_W-1:0]      pick_count_q;

  logic [RANDOM_BITS-1:0] word_q;
  logic [CNT_W-1:0]       bound_q;
  logic [IDX_W-1:0]       pos_q;
  logic [IDX_W-1:0]       src_q;
  logic [ST_W-1:0]        res_status_q, res_status_d;
  logic                   res_last_q, res_last_d;

  logic                   out_valid_q;
  logic [VALUE_W-1:0]     out_value_q;
  logic [POS_W-1:0]       out_pos_q;
  logic [ST_W-1:0]        out_status_q;
  logic                   out_last_q;
  logic                   out_load;

  logic [VALUE_W-1:0]     elem_mem [SET_DEPTH];
  logic [IDX_W-1:0]       pool_mem [SET_DEPTH];
  logic [VALUE_W-1:0]     elem_rd_q;
  logic [IDX_W-1:0]       pool_rd_q;
  logic [IDX_W-1:0]       pool_last_q;
  logic                   elem_we, elem_re, pool_we, pool_re;
  logic [IDX_W-1:0]       elem_raddr, pool_waddr, pool_wdata;

  logic                   in_acc;
  logic [CNT_W-1:0]       bound_c;
  logic [CNT_W-1:0]       bound_m1;
  logic                   err_c, done_c;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [CNT_W-1:0]       div_rem;
  logic [IDX_W-1:0]       pos_c, src_c;
  logic [SUM_W-1:0]       accept_sum;
  logic                   reject_c;

  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;

  // shared remainder unit
  swr_div #(
    .DIVIDEND_W (RANDOM_BITS),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (random_word_i),
    .divisor_i  (bound_c),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // draw bound and early checks
  assign bound_c  = replace_q ? loaded_q : pool_rem_q;
  assign bound_m1 = bound_q - 1'b1;
  assign err_c    = (loaded_q == '0) || (pick_count_q == '0) ||
                    (!replace_q && (CMP_W'(pick_count_q) > CMP_W'(loaded_q))) ||
                    (bound_c == '0);
  assign done_c   = (picks_q >= pick_count_q);

  // word is rejected when its quotient block does not fit under the top word
  assign accept_sum = SUM_W'(word_q) - SUM_W'(div_rem) + SUM_W'(bound_q);
  assign reject_c   = (accept_sum > SUM_W'(WORD_TOP));
  assign pos_c      = div_rem[IDX_W-1:0];

  // pool entries are load positions; guard against an out-of-range index
  assign src_c = (CNT_W'(pool_rd_q) >= CNT_W'(SET_DEPTH)) ? '0 : pool_rd_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    pool_rem_d   = pool_rem_q;
    picks_d      = picks_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    elem_we      = 1'b0;
    elem_re      = 1'b0;
    elem_raddr   = '0;
    pool_we      = 1'b0;
    pool_re      = 1'b0;
    pool_waddr   = '0;
    pool_wdata   = '0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_LOAD: begin
              if ((picks_q == '0) && (loaded_q < CNT_W'(SET_DEPTH))) begin
                elem_we    = 1'b1;
                pool_we    = 1'b1;
                pool_waddr = loaded_q[IDX_W-1:0];
                pool_wdata = loaded_q[IDX_W-1:0];
                loaded_d   = loaded_q + 1'b1;
                pool_rem_d = loaded_q + 1'b1;
              end
            end
            CMD_DRAW: begin
              if (err_c) begin
                res_status_d = ST_ERROR;
                res_last_d   = 1'b0;
                state_d      = S_OUT;
              end else if (done_c) begin
                res_status_d = ST_DONE;
                res_last_d   = 1'b0;
                state_d      = S_OUT;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            CMD_CLEAR: begin
              loaded_d   = '0;
              pool_rem_d = '0;
              picks_d    = '0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (reject_c) begin
            state_d = S_IDLE;
          end else if (replace_q) begin
            elem_re    = 1'b1;
            elem_raddr = pos_c;
            state_d    = S_ELM;
          end else begin
            pool_re = 1'b1;
            state_d = S_WRP;
          end
        end
      end
      S_WRP: begin
        // fill the hole with the last live entry and fetch the element
        pool_we    = 1'b1;
        pool_waddr = pos_q;
        pool_wdata = pool_last_q;
        elem_re    = 1'b1;
        elem_raddr = src_c;
        pool_rem_d = bound_m1;
        state_d    = S_ELM;
      end
      S_ELM: begin
        picks_d      = picks_q + 1'b1;
        res_status_d = ST_PICK;
        res_last_d   = ((picks_q + 1'b1) == pick_count_q);
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      pool_rem_q  <= '0;
      picks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      loaded_q   <= loaded_d;
      pool_rem_q <= pool_rem_d;
      picks_q    <= picks_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // draw operands and staged result
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    if (div_start) begin
      word_q  <= random_word_i;
      bound_q <= bound_c;
    end
    if ((state_q == S_DIV) && div_stat.done) begin
      pos_q <= pos_c;
      src_q <= pos_c;
    end
    if (state_q == S_WRP) begin
      src_q <= src_c;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= (res_status_q == ST_PICK) ? elem_rd_q : '0;
      out_pos_q    <= (res_status_q == ST_PICK) ? POS_W'(src_q) : '0;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign picked_value_o    = out_value_q;
  assign source_position_o = out_pos_q;
  assign status_o          = out_status_q;
  assign last_pick_o       = out_last_q;

  // element store
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[loaded_q[IDX_W-1:0]] <= value_i;
    end
    if (elem_re) begin
      elem_rd_q <= elem_mem[elem_raddr];
    end
  end

  // index pool, chosen slot and last live slot read together
  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    if (pool_re) begin
      pool_rd_q   <= pool_mem[pos_c];
      pool_last_q <= pool_mem[bound_m1[IDX_W-1:0]];
    end
  end

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q    <= 1'b0;
      pick_count_q <= PICK_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REPLACE: replace_q    <= pwdata[0];
        REG_PICK:    pick_count_q <= pwdata[PICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REPLACE: prdata = APB_DW'(replace_q);
      REG_PICK:    prdata = APB_DW'(pick_count_q);
      default:     prdata = '0;
    endcase
  end

  `SWR_ASSERT(a_pool_le_loaded, clk_i, rst_ni, pool_rem_q <= loaded_q, "pool larger than set")
  `SWR_ASSERT(a_load_after_draw, clk_i, rst_ni, (in_acc && (command_i == CMD_LOAD) && (picks_q != '0)) |=> $stable(loaded_q), "load taken after drawing began")
  `SWR_ASSERT(a_non_pick_zero, clk_i, rst_ni, (out_valid_o && (status_o != ST_PICK)) |-> ((picked_value_o == '0) && (source_position_o == '0)), "non-pick result carries data")

endmodule

>>> hdl/swr_div.sv
// ---------------------------------------------------------------------------
// swr_div
// restoring radix-2 remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
`include "sample_without_replacement_assert.svh"

module swr_div import swr_pkg::*; #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output div_stat_t             stat_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W:0]    trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIVIDEND_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIVISOR_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

  `SWR_ASSERT(a_div_start_busy, clk_i, rst_ni, start_i |=> stat_o.busy, "divider did not start")
  `SWR_ASSERT(a_div_rem_range, clk_i, rst_ni, stat_o.done |-> (rem_q < dvs_q), "remainder not below divisor")
  `SWR_NEVER(a_div_done_busy, clk_i, rst_ni, stat_o.done && stat_o.busy, "done raised while busy")

endmodule
